@@ design/best_fit_heap_allocator_assert.svh @@
// assertion macros for the best-fit heap allocator
// expects clk and arst_n in the scope of each use
`ifndef BEST_FIT_HEAP_ALLOCATOR_ASSERT_SVH
`define BEST_FIT_HEAP_ALLOCATOR_ASSERT_SVH

// same-cycle implication
`define BFHA_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define BFHA_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ design/bfha_pkg.sv @@
// shared types and constants for the best-fit heap allocator
// no dependencies
package bfha_pkg;

	localparam logic [15:0] END_MARK = 16'd1;

	typedef enum logic [2:0] {
		ST_OK       = 3'd0,
		ST_BAD_SIZE = 3'd1,
		ST_NO_FIT   = 3'd2,
		ST_NULL     = 3'd3,
		ST_MISALIGN = 3'd4,
		ST_RANGE    = 3'd5,
		ST_FREED    = 3'd6
	} status_t;

	typedef enum logic [4:0] {
		OP_NONE,
		OP_CLEAR,
		OP_START,
		OP_A_WALK,
		OP_A_SPLIT_H,
		OP_A_SPLIT_F,
		OP_A_RD_NEXT,
		OP_A_FIX_NEXT,
		OP_A_HDR,
		OP_F_WALK,
		OP_F_RD_NEXT,
		OP_F_FIX_NEXT,
		OP_F_RD_FOOT,
		OP_F_PREV,
		OP_F_HDR,
		OP_F_WR_HDR,
		OP_F_WR_FOOT,
		OP_RESULT
	} dp_op_t;

	typedef struct packed {
		dp_op_t  op;
		status_t status;
	} dp_cmd_t;

	typedef struct packed {
		logic clr_last;
		logic is_free;
		logic size_zero;
		logic addr_null;
		logic addr_misal;
		logic rd_end;
		logic rd_zero;
		logic rd_alloc;
		logic fit_hit;
		logic pos_hit;
		logic have;
		logic rem_zero;
		logic prev_free;
	} dp_stat_t;

endpackage

@@ design/bfha_if.sv @@
// request and response channel interfaces for the heap allocator
// no dependencies
interface bfha_req_if;
	logic        valid;
	logic        ready;
	logic        req_type;
	logic [11:0] size;
	logic [11:0] address;

	modport source(output valid, req_type, size, address, input ready);
	modport sink(input valid, req_type, size, address, output ready);
endinterface

interface bfha_rsp_if;
	logic        valid;
	logic        ready;
	logic [2:0]  status;
	logic [11:0] payload_offset;

	modport source(output valid, status, payload_offset, input ready);
	modport sink(input valid, status, payload_offset, output ready);
endinterface

@@ design/bfha_datapath.sv @@
// heap memory, walk registers and block arithmetic of the allocator
// depends on bfha_pkg
module bfha_datapath #(
	parameter int HEAP_BYTES = 4096
) (
	input  logic              clk,
	input  logic              arst_n,
	input  bfha_pkg::dp_cmd_t cmd,
	output bfha_pkg::dp_stat_t stat,
	input  logic              req_type,
	input  logic [11:0]       size,
	input  logic [11:0]       address,
	output logic [2:0]        status,
	output logic [11:0]       payload_offset
);
	localparam int HEAP_WORDS = HEAP_BYTES / 4;
	localparam int AW = $clog2(HEAP_WORDS);
	localparam int PW_RAW = $clog2(HEAP_BYTES) + 2;
	localparam int PW = (PW_RAW > 14) ? PW_RAW : 14;
	localparam int INIT_SIZE = (HEAP_BYTES - 8) & ~7;
	localparam logic [PW-3:0] IDX_HDR = (PW-2)'(1);
	localparam logic [PW-3:0] IDX_FOOT = (PW-2)'(INIT_SIZE / 4);
	localparam logic [PW-3:0] IDX_END = (PW-2)'((INIT_SIZE + 4) / 4);
	localparam logic [PW-3:0] IDX_LIMIT = (PW-2)'(HEAP_WORDS);

	logic [15:0] mem [HEAP_WORDS];
	logic [15:0] rdata_q;
	logic        rd_oor_q;
	logic [AW-1:0] clr_q;

	logic        req_type_q;
	logic [11:0] size_q;
	logic [11:0] addr_q;
	logic [PW-1:0] req_q, pos_q, target_q, best_q, best_sz_q, sz_q, blk_q;
	logic        best_prev_q, have_q;
	logic [15:0] h_q, hdr_q;
	logic [2:0]  res_status_q;
	logic [11:0] res_off_q;

	logic [15:0]   rd;
	logic [PW-1:0] rd_sz, hsz, rem, req_in, s4, s4r;
	logic          re, we;
	logic [PW-1:0] ra, wa;
	logic [15:0]   wd, clr_val;
	logic [PW-3:0] ridx, widx, cidx;

	// effective read word, end mark outside the heap
	assign rd = rd_oor_q ? bfha_pkg::END_MARK : rdata_q;
	assign rd_sz = PW'({rd[15:3], 3'b000});
	assign hsz = PW'({h_q[15:3], 3'b000});
	assign rem = best_sz_q - req_q;
	assign s4 = PW'(size) + PW'(4);
	assign s4r = s4 + PW'(7);
	assign req_in = {s4r[PW-1:3], 3'b000};

	// status toward the controller
	assign stat.clr_last   = (clr_q == AW'(HEAP_WORDS - 1));
	assign stat.is_free    = req_type_q;
	assign stat.size_zero  = (size_q == 12'd0);
	assign stat.addr_null  = (addr_q == 12'd0);
	assign stat.addr_misal = (addr_q[2:0] != 3'd0);
	assign stat.rd_end     = (rd == bfha_pkg::END_MARK);
	assign stat.rd_zero    = (rd[15:3] == 13'd0);
	assign stat.rd_alloc   = rd[0];
	assign stat.fit_hit    = !rd[0] && (rd_sz == req_q);
	assign stat.pos_hit    = (pos_q == target_q);
	assign stat.have       = have_q;
	assign stat.rem_zero   = (best_sz_q == req_q);
	assign stat.prev_free  = !h_q[1];

	// reset image of one heap word
	assign cidx = (PW-2)'(clr_q);
	always_comb begin
		if (cidx == IDX_HDR) begin
			clr_val = 16'(INIT_SIZE) | 16'd2;
		end else if (cidx == IDX_FOOT) begin
			clr_val = 16'(INIT_SIZE);
		end else if (cidx == IDX_END) begin
			clr_val = bfha_pkg::END_MARK;
		end else begin
			clr_val = 16'd0;
		end
	end

	// memory port selection per command
	always_comb begin
		re = 1'b0;
		we = 1'b0;
		ra = pos_q;
		wa = best_q;
		wd = 16'd0;
		unique case (cmd.op)
			bfha_pkg::OP_CLEAR: begin
				we = 1'b1;
				wa = {cidx, 2'b00};
				wd = clr_val;
			end
			bfha_pkg::OP_START: begin
				re = 1'b1;
				ra = PW'(4);
			end
			bfha_pkg::OP_A_WALK, bfha_pkg::OP_F_WALK: begin
				re = 1'b1;
				ra = pos_q + rd_sz;
			end
			bfha_pkg::OP_A_SPLIT_H: begin
				we = 1'b1;
				wa = best_q + req_q;
				wd = 16'(rem) | 16'd2;
			end
			bfha_pkg::OP_A_SPLIT_F: begin
				we = 1'b1;
				wa = best_q + best_sz_q - PW'(4);
				wd = 16'(rem);
			end
			bfha_pkg::OP_A_RD_NEXT: begin
				re = 1'b1;
				ra = best_q + req_q;
			end
			bfha_pkg::OP_A_FIX_NEXT: begin
				we = (rd != bfha_pkg::END_MARK);
				wa = best_q + req_q;
				wd = rd | 16'd2;
			end
			bfha_pkg::OP_A_HDR: begin
				we = 1'b1;
				wa = best_q;
				wd = 16'(req_q) | {14'd0, best_prev_q, 1'b1};
			end
			bfha_pkg::OP_F_RD_NEXT: begin
				re = 1'b1;
				ra = target_q + hsz;
			end
			bfha_pkg::OP_F_FIX_NEXT: begin
				we = (rd != bfha_pkg::END_MARK);
				wa = target_q + hsz;
				wd = rd & ~16'd2;
			end
			bfha_pkg::OP_F_RD_FOOT: begin
				re = 1'b1;
				ra = target_q - PW'(4);
			end
			bfha_pkg::OP_F_PREV: begin
				re = 1'b1;
				ra = target_q - rd_sz;
			end
			bfha_pkg::OP_F_WR_HDR: begin
				we = 1'b1;
				wa = blk_q;
				wd = 16'(sz_q) | {14'd0, hdr_q[1], 1'b0};
			end
			bfha_pkg::OP_F_WR_FOOT: begin
				we = 1'b1;
				wa = blk_q + sz_q - PW'(4);
				wd = 16'(sz_q);
			end
			default: begin
			end
		endcase
	end

	assign ridx = ra[PW-1:2];
	assign widx = wa[PW-1:2];

	// heap memory, registered read, writes outside the heap dropped
	always_ff @(posedge clk) begin
		if (we && (widx < IDX_LIMIT)) begin
			mem[widx[AW-1:0]] <= wd;
		end
		if (re) begin
			rdata_q <= mem[ridx[AW-1:0]];
		end
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q    <= '0;
			rd_oor_q <= 1'b0;
			have_q   <= 1'b0;
		end else begin
			if (cmd.op == bfha_pkg::OP_CLEAR) begin
				clr_q <= clr_q + AW'(1);
			end
			if (re) begin
				rd_oor_q <= (ridx >= IDX_LIMIT);
			end
			if (cmd.op == bfha_pkg::OP_START) begin
				have_q <= 1'b0;
			end else if (cmd.op == bfha_pkg::OP_A_WALK && !stat.rd_end && !stat.rd_zero
					&& !rd[0] && (stat.fit_hit || ((rd_sz > req_q)
					&& (!have_q || rd_sz < best_sz_q)))) begin
				have_q <= 1'b1;
			end
		end
	end

	// walk and merge registers
	always_ff @(posedge clk) begin
		case (cmd.op)
			bfha_pkg::OP_START: begin
				req_type_q <= req_type;
				size_q     <= size;
				addr_q     <= address;
				req_q      <= req_in;
				target_q   <= PW'(address) - PW'(4);
				pos_q      <= PW'(4);
			end
			bfha_pkg::OP_A_WALK: begin
				if (!stat.rd_end && !stat.rd_zero && !rd[0] && (stat.fit_hit
						|| ((rd_sz > req_q) && (!have_q || rd_sz < best_sz_q)))) begin
					best_q      <= pos_q;
					best_sz_q   <= rd_sz;
					best_prev_q <= rd[1];
				end
				pos_q <= pos_q + rd_sz;
			end
			bfha_pkg::OP_F_WALK: begin
				h_q   <= rd;
				pos_q <= pos_q + rd_sz;
			end
			bfha_pkg::OP_F_RD_NEXT: begin
				sz_q  <= hsz;
				blk_q <= target_q;
				hdr_q <= h_q;
			end
			bfha_pkg::OP_F_FIX_NEXT: begin
				if (!stat.rd_end && !rd[0]) begin
					sz_q <= sz_q + rd_sz;
				end
			end
			bfha_pkg::OP_F_PREV: begin
				sz_q  <= sz_q + rd_sz;
				blk_q <= target_q - rd_sz;
			end
			bfha_pkg::OP_F_HDR: begin
				hdr_q <= rd;
			end
			bfha_pkg::OP_RESULT: begin
				res_status_q <= cmd.status;
				res_off_q    <= (cmd.status == bfha_pkg::ST_OK && !req_type_q)
					? 12'(best_q + PW'(4)) : 12'd0;
			end
			default: begin
			end
		endcase
	end

	assign status = res_status_q;
	assign payload_offset = res_off_q;

endmodule

@@ design/bfha_ctrl.sv @@
// sequencing state machine of the heap allocator
// depends on bfha_pkg
module bfha_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	output logic               out_valid,
	input  logic               out_ready,
	input  bfha_pkg::dp_stat_t stat,
	output bfha_pkg::dp_cmd_t  cmd
);
	typedef enum logic [4:0] {
		S_CLR, S_IDLE, S_DECODE, S_A_WALK, S_A_COMMIT, S_A_SPLIT_F, S_A_FIX,
		S_A_HDR, S_F_WALK, S_F_NEXT, S_F_FIX, S_F_FOOT, S_F_PREV, S_F_HDR,
		S_F_WHDR, S_F_WFOOT, S_RES
	} state_t;

	state_t              state_q;
	bfha_pkg::status_t   res_code_q;
	logic                out_valid_q;
	logic                res_go;

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;
	assign res_go    = !out_valid_q || out_ready;

	// command per state
	always_comb begin
		cmd.status = res_code_q;
		unique case (state_q)
			S_CLR:       cmd.op = bfha_pkg::OP_CLEAR;
			S_IDLE:      cmd.op = in_valid ? bfha_pkg::OP_START : bfha_pkg::OP_NONE;
			S_DECODE:    cmd.op = bfha_pkg::OP_NONE;
			S_A_WALK:    cmd.op = bfha_pkg::OP_A_WALK;
			S_A_COMMIT:  cmd.op = stat.rem_zero ? bfha_pkg::OP_A_RD_NEXT
				: bfha_pkg::OP_A_SPLIT_H;
			S_A_SPLIT_F: cmd.op = bfha_pkg::OP_A_SPLIT_F;
			S_A_FIX:     cmd.op = bfha_pkg::OP_A_FIX_NEXT;
			S_A_HDR:     cmd.op = bfha_pkg::OP_A_HDR;
			S_F_WALK:    cmd.op = bfha_pkg::OP_F_WALK;
			S_F_NEXT:    cmd.op = bfha_pkg::OP_F_RD_NEXT;
			S_F_FIX:     cmd.op = bfha_pkg::OP_F_FIX_NEXT;
			S_F_FOOT:    cmd.op = bfha_pkg::OP_F_RD_FOOT;
			S_F_PREV:    cmd.op = bfha_pkg::OP_F_PREV;
			S_F_HDR:     cmd.op = bfha_pkg::OP_F_HDR;
			S_F_WHDR:    cmd.op = bfha_pkg::OP_F_WR_HDR;
			S_F_WFOOT:   cmd.op = bfha_pkg::OP_F_WR_FOOT;
			S_RES:       cmd.op = res_go ? bfha_pkg::OP_RESULT : bfha_pkg::OP_NONE;
			default:     cmd.op = bfha_pkg::OP_NONE;
		endcase
	end

	// state and registered outputs
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLR;
			res_code_q  <= bfha_pkg::ST_OK;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_CLR: begin
					if (stat.clr_last) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (in_valid) begin
						state_q <= S_DECODE;
					end
				end
				S_DECODE: begin
					if (!stat.is_free) begin
						if (stat.size_zero) begin
							res_code_q <= bfha_pkg::ST_BAD_SIZE;
							state_q    <= S_RES;
						end else begin
							state_q <= S_A_WALK;
						end
					end else if (stat.addr_null) begin
						res_code_q <= bfha_pkg::ST_NULL;
						state_q    <= S_RES;
					end else if (stat.addr_misal) begin
						res_code_q <= bfha_pkg::ST_MISALIGN;
						state_q    <= S_RES;
					end else begin
						state_q <= S_F_WALK;
					end
				end
				// one block header per cycle until the end mark, a zero size or an exact fit
				S_A_WALK: begin
					if (stat.rd_end || stat.rd_zero) begin
						if (stat.have) begin
							state_q <= S_A_COMMIT;
						end else begin
							res_code_q <= bfha_pkg::ST_NO_FIT;
							state_q    <= S_RES;
						end
					end else if (stat.fit_hit) begin
						state_q <= S_A_COMMIT;
					end
				end
				S_A_COMMIT: begin
					state_q <= stat.rem_zero ? S_A_FIX : S_A_SPLIT_F;
				end
				S_A_SPLIT_F: state_q <= S_A_HDR;
				S_A_FIX:     state_q <= S_A_HDR;
				S_A_HDR: begin
					res_code_q <= bfha_pkg::ST_OK;
					state_q    <= S_RES;
				end
				// search for the freed block on the list
				S_F_WALK: begin
					if (stat.rd_end) begin
						res_code_q <= bfha_pkg::ST_RANGE;
						state_q    <= S_RES;
					end else if (stat.pos_hit) begin
						if (!stat.rd_alloc) begin
							res_code_q <= bfha_pkg::ST_FREED;
							state_q    <= S_RES;
						end else begin
							state_q <= S_F_NEXT;
						end
					end else if (stat.rd_zero) begin
						res_code_q <= bfha_pkg::ST_RANGE;
						state_q    <= S_RES;
					end
				end
				S_F_NEXT: state_q <= S_F_FIX;
				S_F_FIX:  state_q <= stat.prev_free ? S_F_FOOT : S_F_WHDR;
				S_F_FOOT: state_q <= S_F_PREV;
				S_F_PREV: state_q <= S_F_HDR;
				S_F_HDR:  state_q <= S_F_WHDR;
				S_F_WHDR: state_q <= S_F_WFOOT;
				S_F_WFOOT: begin
					res_code_q <= bfha_pkg::ST_OK;
					state_q    <= S_RES;
				end
				S_RES: begin
					if (res_go) begin
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

@@ design/best_fit_heap_allocator.sv @@
// Best-fit heap allocator over an implicit free list of 16-bit header words held in one
// HEAP_BYTES/4-word memory. After reset the block runs a clearing pass over HEAP_BYTES/4
// words (1024 at the default size) that writes the initial heap image, with the request
// channel not ready. Requests are taken one at a time. An allocate walks the list reading
// one header per cycle from the single memory read port, until the end or an exact fit,
// then splits the chosen block if it is larger, writes its header and returns the result.
// A free walks the list the same way up to its block and then merges with its neighbors.
// Error answers for zero size, null or misaligned pointers go from decode straight to the
// result. The next request is taken while the previous result waits in the output
// register.
// depends on bfha_pkg, bfha_if, bfha_ctrl, bfha_datapath, best_fit_heap_allocator_assert.svh
module best_fit_heap_allocator #(
	parameter int HEAP_BYTES = 4096
) (
	input  logic        clk,
	input  logic        arst_n,
	bfha_req_if.sink    req,
	bfha_rsp_if.source  rsp
);
`include "best_fit_heap_allocator_assert.svh"

	bfha_pkg::dp_cmd_t  cmd;
	bfha_pkg::dp_stat_t stat;

	// sequencer
	bfha_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req.valid),
		.in_ready  (req.ready),
		.out_valid (rsp.valid),
		.out_ready (rsp.ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	// heap memory and arithmetic
	bfha_datapath #(
		.HEAP_BYTES (HEAP_BYTES)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.stat           (stat),
		.req_type       (req.req_type),
		.size           (req.size),
		.address        (req.address),
		.status         (rsp.status),
		.payload_offset (rsp.payload_offset)
	);

	// one request in flight at a time
	`BFHA_ASSERT_NEXT(a_one_in_flight, req.valid && req.ready, !req.ready, "request taken while busy")
	// failed requests carry no offset
	`BFHA_ASSERT_NOW(a_err_no_offset, rsp.valid && rsp.status != bfha_pkg::ST_OK, rsp.payload_offset == 12'd0, "offset on error")
	// granted payloads are 8-byte aligned
	`BFHA_ASSERT_NOW(a_offset_aligned, rsp.valid && rsp.status == bfha_pkg::ST_OK, rsp.payload_offset[2:0] == 3'd0, "misaligned payload")

endmodule
